// File: src/wbag_pkg.sv
// wbag_pkg: shared types, codes and helpers for the window blit address generator
// no dependencies; imported by every module under src

`timescale 1ns / 1ps

package wbag_pkg;

	// default flash address width
	localparam int ADDR_BITS_DEF = 24;

	// result word codes
	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_CURSOR = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// input word op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [9:0]  screen_x;
		logic [9:0]  screen_y;
		logic [9:0]  rect_width;
		logic [9:0]  rect_height;
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic [11:0] src_width;
		logic [23:0] src_base;
		logic [7:0]  flash_byte;
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] read_address;
		logic [9:0]  cursor_x;
		logic [10:0] cursor_y;
		logic [7:0]  pixel_byte;
		logic        last;
	} out_word_t;

	// up to three result words from one input word, w0 goes out first
	typedef struct packed {
		logic [1:0] count;
		out_word_t  w2;
		out_word_t  w1;
		out_word_t  w0;
	} res_set_t;

	// builds a result word, fields without meaning are zero
	function automatic out_word_t make_word(kind_t k, logic [23:0] addr, logic [9:0] cx,
			logic [10:0] cy, logic [7:0] pb, logic lst);
		out_word_t w;
		w.kind         = k;
		w.read_address = addr;
		w.cursor_x     = cx;
		w.cursor_y     = cy;
		w.pixel_byte   = pb;
		w.last         = lst;
		return w;
	endfunction

endpackage

// File: src/wbag_core.sv
// wbag_core: blit geometry state and the per-word result logic
// depends on wbag_pkg

`timescale 1ns / 1ps

module wbag_core import wbag_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  in_word_t item_s1,
	output res_set_t res_set
);

	localparam int SumBits = (ADDR_BITS > 26) ? ADDR_BITS : 26;

	logic                 busy_q;
	logic [10:0]          current_row_q;
	logic [10:0]          byte_column_q;
	logic [9:0]           left_column_q;
	logic [10:0]          bytes_per_row_q;
	logic [10:0]          stop_row_q;
	logic [ADDR_BITS-1:0] row_address_q;
	logic [12:0]          row_stride_q;

	logic                 busy_d;
	logic [10:0]          current_row_d;
	logic [10:0]          byte_column_d;
	logic [9:0]           left_column_d;
	logic [10:0]          bytes_per_row_d;
	logic [10:0]          stop_row_d;
	logic [ADDR_BITS-1:0] row_address_d;
	logic [12:0]          row_stride_d;

	logic [12:0]          start_stride;
	logic [24:0]          stride_prod;
	logic [SumBits-1:0]   start_sum;
	logic [ADDR_BITS-1:0] start_addr;
	logic [ADDR_BITS-1:0] step_addr;
	logic [SumBits-1:0]   start_wide;
	logic [SumBits-1:0]   step_wide;
	logic [10:0]          col_inc;
	logic [10:0]          row_inc;

	// first row address: base + src_y * stride + src_x * 2, wrapped to the address width
	assign start_stride = {1'b0, item_s1.src_width} << 1;
	assign stride_prod  = 25'(item_s1.src_y) * 25'(start_stride);
	assign start_sum    = SumBits'(item_s1.src_base) + SumBits'(stride_prod)
		+ SumBits'({item_s1.src_x, 1'b0});
	assign start_addr   = start_sum[ADDR_BITS-1:0];
	assign step_addr    = row_address_q + ADDR_BITS'(row_stride_q);
	assign start_wide   = SumBits'(start_addr);
	assign step_wide    = SumBits'(step_addr);
	assign col_inc      = byte_column_q + 11'd1;
	assign row_inc      = current_row_q + 11'd1;

	always_comb begin
		busy_d          = busy_q;
		current_row_d   = current_row_q;
		byte_column_d   = byte_column_q;
		left_column_d   = left_column_q;
		bytes_per_row_d = bytes_per_row_q;
		stop_row_d      = stop_row_q;
		row_address_d   = row_address_q;
		row_stride_d    = row_stride_q;
		res_set         = '0;
		if (item_s1.op == OP_START) begin
			if (item_s1.rect_width == 10'd0 || item_s1.rect_height == 10'd0) begin
				busy_d        = 1'b0;
				res_set.count = 2'd1;
				res_set.w0    = make_word(KIND_DONE, '0, '0, '0, '0, 1'b1);
			end else begin
				busy_d          = 1'b1;
				left_column_d   = item_s1.screen_x;
				current_row_d   = {1'b0, item_s1.screen_y};
				byte_column_d   = '0;
				bytes_per_row_d = {item_s1.rect_width, 1'b0};
				stop_row_d      = {1'b0, item_s1.screen_y} + {1'b0, item_s1.rect_height};
				row_stride_d    = start_stride;
				row_address_d   = start_addr;
				res_set.count   = 2'd2;
				res_set.w0      = make_word(KIND_READ, start_wide[23:0], '0, '0, '0, 1'b0);
				res_set.w1      = make_word(KIND_CURSOR, '0, item_s1.screen_x,
					{1'b0, item_s1.screen_y}, '0, 1'b1);
			end
		end else if (busy_q) begin
			res_set.count = 2'd1;
			res_set.w0    = make_word(KIND_DATA, '0, '0, '0, item_s1.flash_byte, 1'b1);
			if (col_inc == bytes_per_row_q) begin
				// end of a row: next row or done
				byte_column_d    = '0;
				current_row_d    = row_inc;
				res_set.w0.last  = 1'b0;
				if (row_inc == stop_row_q) begin
					busy_d        = 1'b0;
					res_set.count = 2'd2;
					res_set.w1    = make_word(KIND_DONE, '0, '0, '0, '0, 1'b1);
				end else begin
					row_address_d = step_addr;
					res_set.count = 2'd3;
					res_set.w1    = make_word(KIND_READ, step_wide[23:0], '0, '0, '0, 1'b0);
					res_set.w2    = make_word(KIND_CURSOR, '0, left_column_q, row_inc,
						'0, 1'b1);
				end
			end else begin
				byte_column_d = col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			current_row_q   <= '0;
			byte_column_q   <= '0;
			left_column_q   <= '0;
			bytes_per_row_q <= '0;
			stop_row_q      <= '0;
			row_address_q   <= '0;
			row_stride_q    <= '0;
		end else if (advance) begin
			busy_q          <= busy_d;
			current_row_q   <= current_row_d;
			byte_column_q   <= byte_column_d;
			left_column_q   <= left_column_d;
			bytes_per_row_q <= bytes_per_row_d;
			stop_row_q      <= stop_row_d;
			row_address_q   <= row_address_d;
			row_stride_q    <= row_stride_d;
		end
	end

	// a running blit always has a nonzero row length and a column inside it
	a_row_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (bytes_per_row_q != 11'd0 && byte_column_q < bytes_per_row_q))
		else $error("blit running with bad row length or column");

	// a three word set always ends with the next row's cursor
	a_three_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_set.count == 2'd3) |-> (res_set.w2.kind == KIND_CURSOR && res_set.w2.last))
		else $error("three word set without closing cursor");

endmodule

// File: src/wbag_result_buf.sv
// wbag_result_buf: holds one input word's result set and sends it out one word a cycle while result_stall is low
// depends on wbag_pkg

`timescale 1ns / 1ps

module wbag_result_buf import wbag_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_set_t  res_set,
	output logic      drain_ok,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	res_set_t   set_q;
	logic [1:0] rd_q;
	logic [1:0] left_q;
	logic       fire;

	assign result_valid = (left_q != 2'd0);
	assign fire         = result_valid && !result_stall;
	// the set can be replaced when nothing remains after this edge
	assign drain_ok     = (left_q == 2'd0) || (left_q == 2'd1 && fire);

	always_comb begin
		case (rd_q)
			2'd0:    result = set_q.w0;
			2'd1:    result = set_q.w1;
			2'd2:    result = set_q.w2;
			default: result = set_q.w0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			left_q <= '0;
		end else if (load && res_set.count != 2'd0) begin
			rd_q   <= '0;
			left_q <= res_set.count;
		end else if (fire) begin
			rd_q   <= rd_q + 2'd1;
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_set.count != 2'd0) begin
			set_q <= res_set;
		end
	end

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, rd_q} + {1'b0, left_q} <= 3'd3))
		else $error("result read pointer past the set");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_set.count != 2'd0) |-> drain_ok)
		else $error("result set overwritten before drained");

	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && left_q == 2'd1 && !(load && res_set.count != 2'd0)) |=> !result_valid)
		else $error("result valid after last word taken");

endmodule

// File: src/window_blit_address_generator.sv
// window_blit_address_generator: top level, input register plus core and result buffer
// depends on wbag_pkg, wbag_core, wbag_result_buf

`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// item      in         item_valid / item_stall       in_word_t  (start geometry or flash byte)
// result    out        result_valid / result_stall   out_word_t (read, cursor, data, done)
//
// one input word is taken per cycle while each word gives at most one result word and result_stall is low
// a start gives two result words (one done word for an empty rectangle) and a row end gives
// a read and a cursor after the data word (only a done word on the last row), so the input
// holds off there: the output sends one word a cycle unless result_stall is high
// reset clears the blit state and empties both the input register and the result buffer
// result_stall freezes the shown word; the input register still takes one more word

module window_blit_address_generator import wbag_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	// input register
	logic     valid_s1;
	in_word_t item_s1;

	logic     accept;
	logic     advance;
	logic     drain_ok;
	logic     no_result;
	res_set_t res_set;

	// a byte while idle makes no result words and can always pass
	assign advance    = valid_s1 && (drain_ok || no_result);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign no_result  = (res_set.count == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// blit state and result words for the word in the input register
	wbag_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res_set (res_set)
	);

	// result register, drained one word per cycle unless result_stall is high
	wbag_result_buf u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.res_set      (res_set),
		.drain_ok     (drain_ok),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// the input register only empties by moving its word on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input word lost");

endmodule
